// File: rtl/fspa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed slot pool allocator package
// Shared constants, register map and result codes for the slot allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

	localparam int unsigned MAX_SLOTS_DEF = 256;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned SIZE_W   = 17;
	localparam int unsigned COUNT_W  = 9;
	localparam int unsigned USED_W   = 9;
	localparam int unsigned OVER_W   = 16;
	localparam int unsigned SRC_W    = 2;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_SLOT_SIZE    = 2'd1;
	localparam logic [1:0] REG_SLOT_COUNT   = 2'd2;

	localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;
	localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST    = 17'd16;
	localparam logic [COUNT_W-1:0] SLOT_COUNT_RST   = 9'd256;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [SRC_W-1:0] SRC_RECYCLED = 2'd0;
	localparam logic [SRC_W-1:0] SRC_FRESH    = 2'd1;
	localparam logic [SRC_W-1:0] SRC_OVERFLOW = 2'd2;
	localparam logic [SRC_W-1:0] SRC_FREE_ACK = 2'd3;

	localparam logic [USED_W-1:0] USED_MAX = 9'h1FF;
	localparam logic [OVER_W-1:0] OVER_MAX = 16'hFFFF;

endpackage

// File: rtl/fspa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fspa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/fixed_slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed slot pool allocator
// Hands out fixed-size slots from one region, recycling freed slots first.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid/in_ready channel: req_type selects an
// allocation or a free, and free_address carries the released address.
// Each request yields exactly one result on the out_valid/out_ready channel,
// carrying the granted address, its source and both occupancy counters.
// A request is taken into an input register and resolved against the free
// stack and counters as it moves into the result register; one request is
// taken every cycle unless the receiver stalls. The top of the free stack
// sits in a register and the entry below it is read ahead from the stack
// RAM, so consecutive pops need no stall. The APB port sets the region
// base, slot size and slot count; the user must write it only while no
// request is outstanding, which the block does not enforce. Reset empties
// the stack, clears every counter and restores the register defaults; no
// clearing pass is needed. When the receiver stalls, the result register
// holds and one further request may wait in the input register.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator #(
	parameter int unsigned MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fspa_pkg::PADDR_W-1:0]      paddr,
	input  logic [fspa_pkg::PDATA_W-1:0]      pwdata,
	output logic [fspa_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [fspa_pkg::ADDR_W-1:0]       free_address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fspa_pkg::ADDR_W-1:0]       grant_address,
	output logic [fspa_pkg::SRC_W-1:0]        grant_source,
	output logic [fspa_pkg::USED_W-1:0]       in_use_count,
	output logic [fspa_pkg::OVER_W-1:0]       overflow_count
);

	localparam int unsigned FW   = $clog2(MAX_SLOTS + 1);
	localparam int unsigned AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned PW   = FW + fspa_pkg::SIZE_W + 1;
	localparam int unsigned HI_W = (PW > fspa_pkg::ADDR_W + 1) ? PW : fspa_pkg::ADDR_W + 1;

	logic [fspa_pkg::ADDR_W-1:0]  base_address_q;
	logic [fspa_pkg::SIZE_W-1:0]  slot_size_q;
	logic [fspa_pkg::COUNT_W-1:0] slot_count_q;
	logic [HI_W-1:0]              region_hi;

	logic [FW-1:0]                stack_fill_q;
	logic [FW-1:0]                served_q;
	logic [fspa_pkg::USED_W-1:0]  used_q;
	logic [fspa_pkg::OVER_W-1:0]  over_q;
	logic [fspa_pkg::ADDR_W-1:0]  top_q;

	logic                         valid_s1;
	logic                         req_type_s1;
	logic [fspa_pkg::ADDR_W-1:0]  free_address_s1;

	logic                         valid_s2;
	logic [fspa_pkg::ADDR_W-1:0]  grant_address_s2;
	logic [fspa_pkg::SRC_W-1:0]   grant_source_s2;

	logic                         cfg_write;
	logic                         s2_free;
	logic                         advance;
	logic [FW-1:0]                eff_count;
	logic                         in_region;
	logic [fspa_pkg::ADDR_W-1:0]  fresh_addr;
	logic [fspa_pkg::ADDR_W-1:0]  second_entry;

	logic [FW-1:0]                fill_d;
	logic [FW-1:0]                served_d;
	logic [fspa_pkg::USED_W-1:0]  used_d;
	logic [fspa_pkg::OVER_W-1:0]  over_d;
	logic [fspa_pkg::ADDR_W-1:0]  top_d;
	logic [fspa_pkg::ADDR_W-1:0]  grant_d;
	logic [fspa_pkg::SRC_W-1:0]   source_d;
	logic                         push;
	logic [AW-1:0]                rd_addr;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3:2])
			fspa_pkg::REG_BASE_ADDRESS: prdata = base_address_q;
			fspa_pkg::REG_SLOT_SIZE:    prdata = fspa_pkg::PDATA_W'(slot_size_q);
			fspa_pkg::REG_SLOT_COUNT:   prdata = fspa_pkg::PDATA_W'(slot_count_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= fspa_pkg::BASE_ADDRESS_RST;
			slot_size_q    <= fspa_pkg::SLOT_SIZE_RST;
			slot_count_q   <= fspa_pkg::SLOT_COUNT_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				fspa_pkg::REG_BASE_ADDRESS: base_address_q <= pwdata;
				fspa_pkg::REG_SLOT_SIZE:    slot_size_q    <= pwdata[fspa_pkg::SIZE_W-1:0];
				fspa_pkg::REG_SLOT_COUNT:   slot_count_q   <= pwdata[fspa_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign eff_count = (32'(slot_count_q) < 32'(MAX_SLOTS)) ? FW'(slot_count_q) : FW'(MAX_SLOTS);

	assign region_hi = HI_W'(base_address_q) + HI_W'(eff_count) * HI_W'(slot_size_q);

	// Handshake.
	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Request resolution.
	assign fresh_addr = base_address_q + 32'(served_q) * 32'(slot_size_q);
	assign in_region  = (HI_W'(free_address_s1) >= HI_W'(base_address_q))
		&& (HI_W'(free_address_s1) < region_hi);

	always_comb begin
		fill_d   = stack_fill_q;
		served_d = served_q;
		used_d   = used_q;
		over_d   = over_q;
		top_d    = top_q;
		grant_d  = '0;
		source_d = fspa_pkg::SRC_FREE_ACK;
		push     = 1'b0;
		if (advance) begin
			if (req_type_s1 == fspa_pkg::REQ_ALLOC) begin
				if (stack_fill_q != '0) begin
					fill_d   = stack_fill_q - FW'(1);
					grant_d  = top_q;
					top_d    = second_entry;
					source_d = fspa_pkg::SRC_RECYCLED;
					if (used_q != fspa_pkg::USED_MAX) begin
						used_d = used_q + fspa_pkg::USED_W'(1);
					end
				end else if (served_q < eff_count) begin
					served_d = served_q + FW'(1);
					grant_d  = fresh_addr;
					source_d = fspa_pkg::SRC_FRESH;
					if (used_q != fspa_pkg::USED_MAX) begin
						used_d = used_q + fspa_pkg::USED_W'(1);
					end
				end else begin
					source_d = fspa_pkg::SRC_OVERFLOW;
					if (over_q != fspa_pkg::OVER_MAX) begin
						over_d = over_q + fspa_pkg::OVER_W'(1);
					end
				end
			end else begin
				if (in_region) begin
					if (stack_fill_q < FW'(MAX_SLOTS)) begin
						push   = 1'b1;
						fill_d = stack_fill_q + FW'(1);
						top_d  = free_address_s1;
					end
					if (used_q != '0) begin
						used_d = used_q - fspa_pkg::USED_W'(1);
					end
				end else if (over_q != '0) begin
					over_d = over_q - fspa_pkg::OVER_W'(1);
				end
			end
		end
	end

	// Whenever the stack holds two or more entries, the RAM holds the entry just below the top in its read register.
	assign rd_addr = AW'(fill_d - FW'(2));

	fspa_ram #(
		.WIDTH (fspa_pkg::ADDR_W),
		.DEPTH (MAX_SLOTS)
	) u_stack_ram (
		.clk   (clk),
		.we    (push),
		.waddr (AW'(stack_fill_q)),
		.wdata (free_address_s1),
		.raddr (rd_addr),
		.rdata (second_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			stack_fill_q <= '0;
			served_q     <= '0;
			used_q       <= '0;
			over_q       <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			stack_fill_q <= fill_d;
			served_q     <= served_d;
			used_q       <= used_d;
			over_q       <= over_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_type_s1     <= req_type;
			free_address_s1 <= free_address;
		end
		if (advance) begin
			grant_address_s2 <= grant_d;
			grant_source_s2  <= source_d;
		end
		top_q <= top_d;
	end

	assign out_valid      = valid_s2;
	assign grant_address  = grant_address_s2;
	assign grant_source   = grant_source_s2;
	assign in_use_count   = used_q;
	assign overflow_count = over_q;

	// Checks.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stack_fill_q) <= 32'(MAX_SLOTS))
		else $error("free stack fill exceeds its depth");

	a_served_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(served_q) <= 32'(MAX_SLOTS))
		else $error("served slot count exceeds the store depth");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> ($stable(stack_fill_q) && $stable(used_q)
			&& $stable(over_q) && $stable(served_q)))
		else $error("allocator state changed while the result was stalled");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (grant_source_s2 == fspa_pkg::SRC_OVERFLOW
			|| grant_source_s2 == fspa_pkg::SRC_FREE_ACK)) |-> (grant_address_s2 == '0))
		else $error("overflow grant or free acknowledgement carries an address");

endmodule

// File: tb/fspa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot allocator result checker
// Watches the register port and both handshake channels of the slot allocator.
// It keeps its own free stack, counters and region settings, works out the
// grant that each accepted request must produce, and compares every result
// with the oldest outstanding grant, field by field.
// ----------------------------------------------------------------------------
module fspa_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fspa_pkg::PADDR_W-1:0]  paddr,
	input  logic [fspa_pkg::PDATA_W-1:0]  pwdata,
	input  logic                          pready,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          req_type,
	input  logic [fspa_pkg::ADDR_W-1:0]   free_address,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [fspa_pkg::ADDR_W-1:0]   grant_address,
	input  logic [fspa_pkg::SRC_W-1:0]    grant_source,
	input  logic [fspa_pkg::USED_W-1:0]   in_use_count,
	input  logic [fspa_pkg::OVER_W-1:0]   overflow_count,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		logic [fspa_pkg::ADDR_W-1:0] addr;
		logic [fspa_pkg::SRC_W-1:0]  src;
		logic [fspa_pkg::USED_W-1:0] used;
		logic [fspa_pkg::OVER_W-1:0] over;
	} grant_t;

	logic [fspa_pkg::ADDR_W-1:0]  region_base;
	logic [fspa_pkg::SIZE_W-1:0]  region_size;
	logic [fspa_pkg::COUNT_W-1:0] region_count;
	logic [fspa_pkg::ADDR_W-1:0]  recycle_stack [fspa_pkg::MAX_SLOTS_DEF];
	int unsigned                  stack_depth;
	int unsigned                  fresh_served;
	logic [fspa_pkg::USED_W-1:0]  slots_held;
	logic [fspa_pkg::OVER_W-1:0]  excess_grants;
	grant_t                       grants_due [$];
	grant_t                       oldest;

	function automatic grant_t allocate_or_release(input logic kind,
			input logic [fspa_pkg::ADDR_W-1:0] addr);
		int unsigned usable;
		logic [63:0] lo;
		logic [63:0] hi;
		grant_t      g;
		usable = (region_count < fspa_pkg::MAX_SLOTS_DEF) ? region_count
			: fspa_pkg::MAX_SLOTS_DEF;
		g.addr = '0;
		if (kind == fspa_pkg::REQ_ALLOC) begin
			if (stack_depth > 0) begin
				stack_depth--;
				g.addr = recycle_stack[stack_depth];
				g.src = fspa_pkg::SRC_RECYCLED;
				if (slots_held != fspa_pkg::USED_MAX)
					slots_held++;
			end else if (fresh_served < usable) begin
				g.addr = region_base + fresh_served * region_size;
				fresh_served++;
				g.src = fspa_pkg::SRC_FRESH;
				if (slots_held != fspa_pkg::USED_MAX)
					slots_held++;
			end else begin
				if (excess_grants != fspa_pkg::OVER_MAX)
					excess_grants++;
				g.src = fspa_pkg::SRC_OVERFLOW;
			end
		end else begin
			// The region bound is taken without wrapping to 32 bits.
			lo = 64'(region_base);
			hi = lo + 64'(usable) * 64'(region_size);
			if (64'(addr) >= lo && 64'(addr) < hi) begin
				if (stack_depth < fspa_pkg::MAX_SLOTS_DEF) begin
					recycle_stack[stack_depth] = addr;
					stack_depth++;
				end
				if (slots_held != 0)
					slots_held--;
			end else if (excess_grants != 0) begin
				excess_grants--;
			end
			g.src = fspa_pkg::SRC_FREE_ACK;
		end
		g.used = slots_held;
		g.over = excess_grants;
		return g;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %h, got %h", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base = fspa_pkg::BASE_ADDRESS_RST;
			region_size = fspa_pkg::SLOT_SIZE_RST;
			region_count = fspa_pkg::SLOT_COUNT_RST;
			stack_depth = 0;
			fresh_served = 0;
			slots_held = '0;
			excess_grants = '0;
			grants_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					fspa_pkg::REG_BASE_ADDRESS: region_base = pwdata;
					fspa_pkg::REG_SLOT_SIZE: region_size = pwdata[fspa_pkg::SIZE_W-1:0];
					fspa_pkg::REG_SLOT_COUNT: region_count = pwdata[fspa_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					$error("Unexpected result: address %h, source %0d", grant_address,
						grant_source);
					errors++;
				end else begin
					oldest = grants_due.pop_front();
					check_field("grant_address", oldest.addr, grant_address);
					check_field("grant_source", 32'(oldest.src), 32'(grant_source));
					check_field("in_use_count", 32'(oldest.used), 32'(in_use_count));
					check_field("overflow_count", 32'(oldest.over), 32'(overflow_count));
				end
			end
			if (in_valid && in_ready)
				grants_due.push_back(allocate_or_release(req_type, free_address));
			pending = grants_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate and free requests into the slot allocator, programmes the
// region through the register port between phases and stalls both channels
// at random. Directed requests cover the region edges, the empty region,
// address wrap and full stack, then long runs saturate the in-use count and
// random phases mix well-formed free and allocate sequences with noise.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned HOLD_OFF    = 60;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned PHASES      = 5;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [fspa_pkg::PADDR_W-1:0] paddr;
	logic [fspa_pkg::PDATA_W-1:0] pwdata;
	logic [fspa_pkg::PDATA_W-1:0] prdata;
	logic                         pready;
	logic                         in_valid;
	logic                         in_ready;
	logic                         req_type;
	logic [fspa_pkg::ADDR_W-1:0]  free_address;
	logic                         out_valid;
	logic                         out_ready;
	logic [fspa_pkg::ADDR_W-1:0]  grant_address;
	logic [fspa_pkg::SRC_W-1:0]   grant_source;
	logic [fspa_pkg::USED_W-1:0]  in_use_count;
	logic [fspa_pkg::OVER_W-1:0]  overflow_count;
	int                           errors;
	int                           pending;

	logic                         tx_idle;
	logic                         rx_idle;
	logic                         stall_req;
	int unsigned                  item_count;
	logic [fspa_pkg::ADDR_W-1:0]  cur_base;
	logic [fspa_pkg::SIZE_W-1:0]  cur_size;
	logic [fspa_pkg::COUNT_W-1:0] cur_count;

	fixed_slot_pool_allocator u_top (.*);

	fspa_checker u_checker (.*);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned region_slots();
		return (cur_count < fspa_pkg::MAX_SLOTS_DEF) ? cur_count : fspa_pkg::MAX_SLOTS_DEF;
	endfunction

	function automatic logic [fspa_pkg::ADDR_W-1:0] inside_addr();
		logic [63:0] span;
		logic [63:0] room;
		logic [63:0] lim;
		span = 64'(region_slots()) * 64'(cur_size);
		room = 64'h1_0000_0000 - 64'(cur_base);
		lim = (span < room) ? span : room;
		if (lim == 0 || lim > 64'hFFFF_FFFF)
			return $urandom;
		return cur_base + $urandom_range(32'(lim - 1), 0);
	endfunction

	function automatic logic [fspa_pkg::ADDR_W-1:0] edge_addr();
		logic [fspa_pkg::ADDR_W-1:0] hi;
		hi = cur_base + region_slots() * cur_size;
		case ($urandom_range(0, 3))
			0: return cur_base;
			1: return cur_base - 1;
			2: return hi - 1;
			default: return hi;
		endcase
	endfunction

	task automatic send(input logic kind, input logic [fspa_pkg::ADDR_W-1:0] addr);
		@(negedge clk);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		free_address <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		item_count++;
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_region(input logic [31:0] b, input logic [31:0] s,
			input logic [31:0] c);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		apb_write(fspa_pkg::REG_BASE_ADDRESS, b);
		apb_write(fspa_pkg::REG_SLOT_SIZE, s);
		apb_write(fspa_pkg::REG_SLOT_COUNT, c);
		cur_base = b;
		cur_size = s[fspa_pkg::SIZE_W-1:0];
		cur_count = c[fspa_pkg::COUNT_W-1:0];
	endtask

	task automatic random_region();
		logic [31:0] b;
		logic [31:0] s;
		logic [31:0] c;
		case ($urandom_range(0, 3))
			0: b = '0;
			1: b = 32'hFFFF_F000;
			default: b = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0: s = 32'd1;
			1: s = 32'd16;
			2: s = 32'h1_0000;
			3: s = 32'h1_FFFF;
			4: s = '0;
			default: s = $urandom_range(1, 4096);
		endcase
		case ($urandom_range(0, 4))
			0: c = '0;
			1: c = 32'd1;
			2: c = 32'd256;
			3: c = 32'd511;
			default: c = $urandom_range(2, 300);
		endcase
		set_region(b, s, c);
	endtask

	initial begin
		bit stall_done;
		stall_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req && !stall_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF - 1) @(negedge clk);
				stall_done = 1'b1;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = fspa_pkg::REQ_ALLOC;
		free_address = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		stall_req = 1'b0;
		item_count = 0;
		cur_base = fspa_pkg::BASE_ADDRESS_RST;
		cur_size = fspa_pkg::SLOT_SIZE_RST;
		cur_count = fspa_pkg::SLOT_COUNT_RST;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Default region: frees at both counters' floor and at the region edges.
		send(fspa_pkg::REQ_FREE, 32'hFFFF_FFFF);
		send(fspa_pkg::REQ_FREE, 32'h0000_0000);
		send(fspa_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
		send(fspa_pkg::REQ_FREE, 32'd4095);
		send(fspa_pkg::REQ_FREE, 32'd4096);
		send(fspa_pkg::REQ_FREE, 32'd16);
		send(fspa_pkg::REQ_ALLOC, 32'h0000_0000);
		send(fspa_pkg::REQ_ALLOC, 32'h0000_0000);

		// An empty region turns every allocation into an overflow request.
		set_region(32'h8000_0000, 32'd0, 32'd0);
		repeat (3) send(fspa_pkg::REQ_ALLOC, $urandom);
		send(fspa_pkg::REQ_FREE, 32'h8000_0000);
		send(fspa_pkg::REQ_FREE, 32'h0000_0000);
		send(fspa_pkg::REQ_ALLOC, $urandom);

		// Fill the stack past its depth, empty it, then hand out every fresh slot
		// under several region settings so that the in-use count saturates.
		set_region(32'h1000_0000, 32'd16, 32'hFFFF_FFFF);
		repeat (257) send(fspa_pkg::REQ_FREE, inside_addr());
		repeat (256) send(fspa_pkg::REQ_ALLOC, $urandom);
		repeat (60) send(fspa_pkg::REQ_ALLOC, $urandom);
		set_region(32'hFFFF_FFF0, 32'd16, 32'd511);
		repeat (50) send(fspa_pkg::REQ_ALLOC, $urandom);
		set_region(32'h1234_5678, 32'h1_0000, 32'd511);
		repeat (50) send(fspa_pkg::REQ_ALLOC, $urandom);
		set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd511);
		repeat (50) send(fspa_pkg::REQ_ALLOC, $urandom);
		set_region(32'hDEAD_BEE0, 32'd0, 32'd511);
		repeat (20) send(fspa_pkg::REQ_ALLOC, $urandom);
		set_region(32'h0000_0000, 32'd1, 32'd256);
		repeat (30) send(fspa_pkg::REQ_ALLOC, $urandom);

		for (int phase = 0; phase < PHASES; phase++) begin
			random_region();
			if (phase == 1)
				stall_req = 1'b1;
			item_count = 0;
			while (item_count < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0: send(1'($urandom_range(0, 1)), $urandom);
					1: send(fspa_pkg::REQ_FREE, edge_addr());
					default: begin
						k = $urandom_range(1, 8);
						repeat (k) send(fspa_pkg::REQ_FREE, inside_addr());
						repeat ($urandom_range(0, 2 * k)) send(fspa_pkg::REQ_ALLOC, $urandom);
					end
				endcase
			end
		end

		// Final stretch at full rate: overflow grants and stray frees.
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_region($urandom, 32'd16, 32'd0);
		repeat (200) send(fspa_pkg::REQ_ALLOC, $urandom);
		repeat (6) send(fspa_pkg::REQ_FREE, $urandom);
		repeat (8) send(fspa_pkg::REQ_ALLOC, $urandom);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/fspa_pkg.sv
rtl/fspa_ram.sv
rtl/fixed_slot_pool_allocator.sv
tb/fspa_checker.sv
tb/tb_top.sv
